// ----- src/profile_following_pi_heater_control_core_defines.svh -----
// ----------------------------------------------------------------------------
// Profile-following PI heater control - assertion macros
// Shared property macros for the checker.
// ----------------------------------------------------------------------------
`ifndef PROFILE_FOLLOWING_PI_HEATER_CONTROL_CORE_DEFINES_SVH
`define PROFILE_FOLLOWING_PI_HEATER_CONTROL_CORE_DEFINES_SVH

// same-cycle implication, reset masked
`define PFPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define PFPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pfpi_pkg.sv -----
// ----------------------------------------------------------------------------
// pfpi_pkg
// Constants, codes and state type of the profile-following PI controller.
// ----------------------------------------------------------------------------
package pfpi_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int SEG_W      = 7;
  localparam int OPW        = 32;               // serial unit operand width
  localparam int CNT_W      = $clog2(OPW);
  localparam int ADDR_W     = 5;

  // func codes
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_ZONE        = 3'd2;
  localparam logic [2:0] REG_WINDOW      = 3'd3;
  localparam logic [2:0] REG_POINT_COUNT = 3'd4;

  // reset values
  localparam logic [19:0] PROP_GAIN_RST  = 20'd98304;
  localparam logic [19:0] INTEG_GAIN_RST = 20'd9830;
  localparam logic [7:0]  ZONE_RST       = 8'd15;
  localparam logic [16:0] WINDOW_RST     = 17'd32768;

  localparam logic [16:0] DUTY_FULL  = 17'h10000;
  localparam logic [13:0] TEMP_MAX   = 14'd16383;
  localparam logic [13:0] MEAS_MAX   = 14'd16380;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEEK, ST_RD0, ST_RD1, ST_EVAL, ST_MUL_T, ST_DIV_T, ST_ERR,
    ST_MUL_W, ST_CHK, ST_MUL_I, ST_MUL_P, ST_DIV_P, ST_FIN
  } state_t;

endpackage

// ----- src/pfpi_mul.sv -----
// ----------------------------------------------------------------------------
// pfpi_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pfpi_mul import pfpi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [OPW-1:0]     a,
  input  logic [OPW-1:0]     b,
  output logic               done,
  output logic [2*OPW-1:0]   prod
);

  logic [OPW-1:0]   a_r, b_r;
  logic [2*OPW-1:0] acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [OPW:0]     sum;

  // add multiplicand into the upper half, then shift right
  assign sum = {1'b0, acc_r[2*OPW-1:OPW]} + (b_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= {sum, acc_r[OPW-1:1]};
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(OPW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ----- src/pfpi_div.sv -----
// ----------------------------------------------------------------------------
// pfpi_div
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfpi_div import pfpi_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [OPW-1:0] num,
  input  logic [OPW-1:0] den,
  output logic           done,
  output logic [OPW-1:0] quo
);

  logic [OPW-1:0]   num_r, den_r, rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [OPW:0]     rem_sh, diff;

  // shift in next dividend bit, trial subtract
  assign rem_sh = {rem_r, num_r[OPW-1]};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!diff[OPW]) begin
          rem_r <= diff[OPW-1:0];
          num_r <= {num_r[OPW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[OPW-1:0];
          num_r <= {num_r[OPW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(OPW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// ----- src/profile_following_pi_heater_control_core.sv -----
// ----------------------------------------------------------------------------
// profile_following_pi_heater_control_core
// Heater PI controller following a loaded piecewise-linear profile.
// ----------------------------------------------------------------------------
// Load, start and no-op words pass from ST_IDLE to ST_FIN and then into the
// output register. A tick passes through ST_SEEK, ST_RD0, ST_RD1 and ST_EVAL
// for each profile segment it skips or examines, plus the serial arithmetic:
// one multiply and one divide for the setpoint, one multiply for the
// integral, and, when the error lies inside the zone, two more multiplies and
// one divide. All of these share one bit-serial multiplier and one bit-serial
// divider. One word is worked on at a time; a new word is taken while the
// previous result still waits at the output.
module profile_following_pi_heater_control_core import pfpi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [5:0]        in_point_index,
  input  logic [11:0]       in_point_time,
  input  logic [13:0]       in_point_temp,
  input  logic [11:0]       in_elapsed_seconds,
  input  logic [15:0]       in_thermo_word,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_heater_first_half,
  output logic              out_heater_second_half,
  output logic [16:0]       out_duty,
  output logic [13:0]       out_target_temp,
  output logic signed [14:0] out_temp_error,
  output logic [13:0]       out_measured_temp,
  output logic              out_probe_open,
  output logic [6:0]        out_segment,
  output logic              out_profile_done,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  state_t state_r, state_nxt;

  // configuration registers
  logic [19:0] kp_r, ki_r;
  logic [7:0]  zone_r;
  logic [16:0] window_r;
  logic [6:0]  pcount_r;

  // run state
  logic [SEG_W-1:0]  seg_r;
  logic signed [31:0] integ_r;
  logic               run_r;

  // working registers
  logic [11:0]        elapsed_r;
  logic [25:0]        p0_r;
  logic               sgn_r;
  logic [11:0]        den_r;
  logic [13:0]        meas_r, tgt_r;
  logic               probe_r, done_r;
  logic signed [14:0] err_r;
  logic signed [34:0] iterm_r;
  logic [16:0]        duty_r;

  // output registers
  logic               out_valid_r;
  logic [16:0]        out_duty_r;
  logic [13:0]        out_tgt_r, out_meas_r;
  logic signed [14:0] out_err_r;
  logic               out_probe_r, out_done_r;
  logic [6:0]         out_seg_r;

  // profile memory {time, temp}
  logic [25:0]       profile_mem [MAX_POINTS];
  logic [25:0]       rdata_r;
  logic [PT_AW-1:0]  raddr;
  logic [SEG_W-1:0]  seg_m1;

  // serial units
  logic           mul_start, mul_done, div_start, div_done;
  logic [OPW-1:0] mul_a, mul_b, div_num, div_den, div_quo;
  logic [2*OPW-1:0] mul_prod;

  logic           in_acc, cfg_wr, out_load;
  logic           is_tick;
  logic [SEG_W-1:0] npts;
  logic [11:0]    zone16;
  logic [11:0]    t0, t1;
  logic [13:0]    v0, v1;
  logic signed [14:0] dv;
  logic signed [12:0] de, dd;
  logic [14:0]    dv_mag;
  logic [12:0]    de_mag, dd_mag;
  logic [14:0]    err_mag;
  logic [31:0]    integ_mag;
  logic signed [29:0] qs, tsum;
  logic [13:0]    tgt_c;
  logic signed [14:0] err_c;
  logic signed [33:0] isum, iprod;
  logic [52:0]    irnd;
  logic signed [34:0] iterm_c, dsum;
  logic [13:0]    meas_dec;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign is_tick  = (in_func == FUNC_TICK);

  assign npts   = (pcount_r > SEG_W'(MAX_POINTS)) ? SEG_W'(MAX_POINTS) : pcount_r;
  assign zone16 = {((zone_r == 8'd0) ? 8'd1 : zone_r), 4'd0};

  // thermocouple decode: quarter degrees to 1/16, saturated
  assign meas_dec = in_thermo_word[2] ? 14'd0 :
                    (in_thermo_word[15] ? MEAS_MAX : {in_thermo_word[14:3], 2'b00});

  // segment endpoints
  assign seg_m1 = seg_r - 1'b1;
  assign raddr  = (state_r == ST_RD0) ? seg_m1[PT_AW-1:0] : seg_r[PT_AW-1:0];
  assign t0 = p0_r[25:14];
  assign v0 = p0_r[13:0];
  assign t1 = rdata_r[25:14];
  assign v1 = rdata_r[13:0];
  assign dv = $signed({1'b0, v1}) - $signed({1'b0, v0});
  assign de = $signed({1'b0, elapsed_r}) - $signed({1'b0, t0});
  assign dd = $signed({1'b0, t1}) - $signed({1'b0, t0});
  assign dv_mag = dv[14] ? 15'(-dv) : 15'(dv);
  assign de_mag = de[12] ? 13'(-de) : 13'(de);
  assign dd_mag = dd[12] ? 13'(-dd) : 13'(dd);

  // interpolated target and error
  assign qs   = sgn_r ? -$signed({2'b00, div_quo[27:0]}) : $signed({2'b00, div_quo[27:0]});
  assign tsum = $signed({16'd0, v0}) + qs;
  assign tgt_c = tsum[29] ? 14'd0 : ((tsum > 30'sd16383) ? TEMP_MAX : tsum[13:0]);
  assign err_c = $signed({1'b0, tgt_c}) - $signed({1'b0, meas_r});
  assign err_mag = err_r[14] ? 15'(-err_r) : 15'(err_r);

  // saturating integral update
  assign iprod = err_r[14] ? -$signed({1'b0, mul_prod[32:0]}) : $signed({1'b0, mul_prod[32:0]});
  assign isum  = $signed({{2{integ_r[31]}}, integ_r}) + iprod;
  assign integ_mag = integ_r[31] ? 32'(-integ_r) : 32'(integ_r);

  // floor(ki * integral / 2^20)
  assign irnd = {1'b0, mul_prod[51:0]} + 53'hFFFFF;
  assign iterm_c = integ_r[31] ? -$signed({2'b00, irnd[52:20]})
                               : $signed({3'b000, mul_prod[51:20]});
  assign dsum = iterm_r + $signed({3'b000, div_quo});

  // next state and unit control
  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = mul_prod[OPW-1:0];
    div_den   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc)
          state_nxt = (in_func == FUNC_TICK && run_r) ? ST_SEEK : ST_FIN;
      end
      ST_SEEK: begin
        if (seg_r >= npts)       state_nxt = ST_FIN;
        else if (seg_r != '0)    state_nxt = ST_RD0;
      end
      ST_RD0: state_nxt = ST_RD1;
      ST_RD1: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (t1 == t0 || elapsed_r > t1) begin
          state_nxt = ST_SEEK;
        end else begin
          mul_start = 1'b1;
          mul_a     = {17'd0, dv_mag};
          mul_b     = {19'd0, de_mag};
          state_nxt = ST_MUL_T;
        end
      end
      ST_MUL_T: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_den   = {20'd0, den_r};
          state_nxt = ST_DIV_T;
        end
      end
      ST_DIV_T: if (div_done) state_nxt = ST_ERR;
      ST_ERR: begin
        mul_start = 1'b1;
        mul_a     = {17'd0, err_mag};
        mul_b     = {15'd0, window_r};
        state_nxt = ST_MUL_W;
      end
      ST_MUL_W: if (mul_done) state_nxt = ST_CHK;
      ST_CHK: begin
        if (err_r[14] || err_r > $signed({3'b000, zone16})) begin
          state_nxt = ST_FIN;
        end else begin
          mul_start = 1'b1;
          mul_a     = {12'd0, ki_r};
          mul_b     = integ_mag;
          state_nxt = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = {12'd0, kp_r};
          mul_b     = {17'd0, err_mag};
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_den   = {20'd0, zone16};
          state_nxt = ST_DIV_P;
        end
      end
      ST_DIV_P: if (div_done) state_nxt = ST_FIN;
      ST_FIN:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // profile memory
  always_ff @(posedge clk) begin
    if (in_acc && in_func == FUNC_LOAD)
      profile_mem[in_point_index] <= {in_point_time, in_point_temp};
    rdata_r <= profile_mem[raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= PROP_GAIN_RST;
      ki_r     <= INTEG_GAIN_RST;
      zone_r   <= ZONE_RST;
      window_r <= WINDOW_RST;
      pcount_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_PROP_GAIN:   kp_r     <= cfg_pwdata[19:0];
        REG_INTEG_GAIN:  ki_r     <= cfg_pwdata[19:0];
        REG_ZONE:        zone_r   <= cfg_pwdata[7:0];
        REG_WINDOW:      window_r <= cfg_pwdata[16:0];
        REG_POINT_COUNT: pcount_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_PROP_GAIN:   cfg_prdata = {12'd0, kp_r};
      REG_INTEG_GAIN:  cfg_prdata = {12'd0, ki_r};
      REG_ZONE:        cfg_prdata = {24'd0, zone_r};
      REG_WINDOW:      cfg_prdata = {15'd0, window_r};
      REG_POINT_COUNT: cfg_prdata = {25'd0, pcount_r};
      default:         cfg_prdata = '0;
    endcase
  end
  assign cfg_pready = 1'b1;

  // run state and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r   <= '0;
      integ_r <= '0;
      run_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            elapsed_r <= in_elapsed_seconds;
            tgt_r     <= '0;
            err_r     <= '0;
            duty_r    <= '0;
            // only a tick decodes the reading
            meas_r    <= is_tick ? meas_dec : 14'd0;
            probe_r   <= is_tick && in_thermo_word[2];
            done_r    <= is_tick && !run_r;
            if (in_func == FUNC_START) begin
              integ_r <= '0;
              seg_r   <= '0;
              run_r   <= 1'b1;
            end
          end
        end
        ST_SEEK: begin
          if (seg_r >= npts)    done_r <= 1'b1;
          else if (seg_r == '0) seg_r  <= seg_r + 1'b1;
        end
        ST_RD1: p0_r <= rdata_r;
        ST_EVAL: begin
          if (t1 == t0 || elapsed_r > t1) seg_r <= seg_r + 1'b1;
          sgn_r <= dv[14] ^ de[12] ^ dd[12];
          den_r <= dd_mag[11:0];
        end
        ST_DIV_T: begin
          if (div_done) begin
            tgt_r <= tgt_c;
            err_r <= err_c;
          end
        end
        ST_MUL_W: begin
          if (mul_done) begin
            if (isum > 34'sh07FFFFFFF)       integ_r <= 32'sh7FFFFFFF;
            else if (isum < -34'sh080000000) integ_r <= 32'sh80000000;
            else                             integ_r <= isum[31:0];
          end
        end
        ST_CHK: begin
          if (!err_r[14] && err_r > $signed({3'b000, zone16})) duty_r <= DUTY_FULL;
        end
        ST_MUL_I: if (mul_done) iterm_r <= iterm_c;
        ST_DIV_P: begin
          if (div_done) begin
            if (dsum[34])                           duty_r <= '0;
            else if (dsum > $signed({18'd0, DUTY_FULL})) duty_r <= DUTY_FULL;
            else                                    duty_r <= dsum[16:0];
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      out_duty_r  <= duty_r;
      out_tgt_r   <= tgt_r;
      out_err_r   <= err_r;
      out_meas_r  <= meas_r;
      out_probe_r <= probe_r;
      out_seg_r   <= seg_r;
      out_done_r  <= done_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_duty               = out_duty_r;
  assign out_heater_first_half  = (out_duty_r != '0);
  assign out_heater_second_half = out_duty_r[16];
  assign out_target_temp        = out_tgt_r;
  assign out_temp_error         = out_err_r;
  assign out_measured_temp      = out_meas_r;
  assign out_probe_open         = out_probe_r;
  assign out_segment            = out_seg_r;
  assign out_profile_done       = out_done_r;

  pfpi_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  pfpi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

// ----- src/pfpi_checker.sv -----
// ----------------------------------------------------------------------------
// pfpi_checker
// Port-level checks on the result channel of the heater controller.
// ----------------------------------------------------------------------------
`include "profile_following_pi_heater_control_core_defines.svh"

module pfpi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_heater_first_half,
  input logic        out_heater_second_half,
  input logic [16:0] out_duty,
  input logic [13:0] out_target_temp,
  input logic [13:0] out_measured_temp,
  input logic        out_probe_open,
  input logic        out_profile_done
);

  // stalled word stays valid and its duty holds
  `PFPI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_duty), "result word changed while stalled")
  // heater bits follow duty
  `PFPI_ASSERT_NOW(a_first_half, out_valid, out_heater_first_half == (out_duty != 17'd0), "first-half heater mismatch")
  `PFPI_ASSERT_NOW(a_second_half, out_valid, out_heater_second_half == (out_duty == 17'h10000), "second-half heater mismatch")
  // finished or idle profile drives heater off
  `PFPI_ASSERT_NOW(a_done_off, out_valid && out_profile_done, out_duty == 17'd0 && out_target_temp == 14'd0, "heater on after profile done")
  // open probe reads zero
  `PFPI_ASSERT_NOW(a_probe_zero, out_valid && out_probe_open, out_measured_temp == 14'd0, "open probe with nonzero temperature")

endmodule

bind profile_following_pi_heater_control_core pfpi_checker u_pfpi_checker (.*);
